### sv/keyed_doubly_linked_table_defines.svh
// Assertion macros shared by the table's modules.
// IMP checks the consequent in the same cycle, NEXT in the cycle after.
`ifndef KEYED_DOUBLY_LINKED_TABLE_DEFINES_SVH
`define KEYED_DOUBLY_LINKED_TABLE_DEFINES_SVH

`define KDLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define KDLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/kdlt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kdlt_pkg;

  // Defaults for the top level parameters
  localparam int POOL_DEPTH_DEF    = 64;
  localparam int PAYLOAD_BYTES_DEF = 4;

  // Fixed field widths
  localparam int CMD_W    = 3;
  localparam int KEY_W    = 16;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;
  localparam int CAP_W    = 7;

  // Register port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [0:0]       REG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0] CAP_RESET    = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT    = 3'd0,
    CMD_REMOVE    = 3'd1,
    CMD_FIND      = 3'd2,
    CMD_FIND_NEXT = 3'd3,
    CMD_FIND_PREV = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_NOT_FOUND    = 2'd2,
    ST_NO_NEIGHBOUR = 2'd3
  } status_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    found_key;
    logic [DATA_W-1:0]   found_data;
    logic [COUNT_W-1:0]  entry_count;
  } out_item_t;

  // Controller states
  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_INS_WR   = 8'b0000_0010,
    S_INS_LINK = 8'b0000_0100,
    S_WALK     = 8'b0000_1000,
    S_REM_A    = 8'b0001_0000,
    S_REM_B    = 8'b0010_0000,
    S_NB_RD    = 8'b0100_0000,
    S_RESP     = 8'b1000_0000
  } state_e;

  // Source of the result fields
  typedef enum logic [2:0] {
    RES_OK           = 3'd0,
    RES_FULL         = 3'd1,
    RES_NOT_FOUND    = 3'd2,
    RES_NO_NEIGHBOUR = 3'd3,
    RES_ENTRY        = 3'd4
  } res_src_e;

  // Controller to datapath commands
  typedef struct packed {
    logic     latch_item;
    logic     rd_free;
    logic     rd_head;
    logic     rd_next;
    logic     rd_prev;
    logic     walk_step;
    logic     ins_write;
    logic     ins_link;
    logic     rem_latch;
    logic     rem_unlink;
    logic     rem_free;
    logic     set_res;
    res_src_e res_src;
    logic     load_out;
  } dp_ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             head_null;
    logic             tail_null;
    logic             key_hit;
    logic             next_null;
    logic             prev_null;
    logic             walk_end;
  } dp_stat_t;

endpackage

`default_nettype wire

### sv/kdlt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "keyed_doubly_linked_table_defines.svh"

module kdlt_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic [kdlt_pkg::CMD_W-1:0] in_cmd_i,
  output logic                           in_ready_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  input  wire kdlt_pkg::dp_stat_t        stat_i,
  output kdlt_pkg::dp_ctrl_t             ctrl_o
);

  kdlt_pkg::state_e   state_q, state_d;
  logic               out_valid_q, out_valid_d;
  logic               accept;
  kdlt_pkg::dp_ctrl_t ctrl;

  assign in_ready_o  = (state_q == kdlt_pkg::S_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign ctrl_o      = ctrl;

  // Sequence one command through the datapath
  always_comb begin
    ctrl    = '0;
    state_d = state_q;
    case (state_q)
      kdlt_pkg::S_IDLE: begin
        if (accept) begin
          ctrl.latch_item = 1'b1;
          case (in_cmd_i)
            kdlt_pkg::CMD_INSERT: begin
              if (stat_i.full) begin
                ctrl.set_res = 1'b1;
                ctrl.res_src = kdlt_pkg::RES_FULL;
                state_d      = kdlt_pkg::S_RESP;
              end else begin
                ctrl.rd_free = 1'b1;
                state_d      = kdlt_pkg::S_INS_WR;
              end
            end
            kdlt_pkg::CMD_REMOVE, kdlt_pkg::CMD_FIND,
            kdlt_pkg::CMD_FIND_NEXT, kdlt_pkg::CMD_FIND_PREV: begin
              if (stat_i.head_null) begin
                ctrl.set_res = 1'b1;
                ctrl.res_src = kdlt_pkg::RES_NOT_FOUND;
                state_d      = kdlt_pkg::S_RESP;
              end else begin
                ctrl.rd_head = 1'b1;
                state_d      = kdlt_pkg::S_WALK;
              end
            end
            default: begin
              ctrl.set_res = 1'b1;
              ctrl.res_src = kdlt_pkg::RES_OK;
              state_d      = kdlt_pkg::S_RESP;
            end
          endcase
        end
      end
      kdlt_pkg::S_INS_WR: begin
        ctrl.ins_write = 1'b1;
        ctrl.set_res   = 1'b1;
        ctrl.res_src   = kdlt_pkg::RES_OK;
        state_d        = stat_i.tail_null ? kdlt_pkg::S_RESP : kdlt_pkg::S_INS_LINK;
      end
      kdlt_pkg::S_INS_LINK: begin
        ctrl.ins_link = 1'b1;
        state_d       = kdlt_pkg::S_RESP;
      end
      kdlt_pkg::S_WALK: begin
        if (stat_i.key_hit) begin
          case (stat_i.cmd)
            kdlt_pkg::CMD_REMOVE: begin
              ctrl.rem_latch = 1'b1;
              ctrl.set_res   = 1'b1;
              ctrl.res_src   = kdlt_pkg::RES_OK;
              state_d        = kdlt_pkg::S_REM_A;
            end
            kdlt_pkg::CMD_FIND_NEXT: begin
              if (stat_i.next_null) begin
                ctrl.set_res = 1'b1;
                ctrl.res_src = kdlt_pkg::RES_NO_NEIGHBOUR;
                state_d      = kdlt_pkg::S_RESP;
              end else begin
                ctrl.rd_next = 1'b1;
                state_d      = kdlt_pkg::S_NB_RD;
              end
            end
            kdlt_pkg::CMD_FIND_PREV: begin
              if (stat_i.prev_null) begin
                ctrl.set_res = 1'b1;
                ctrl.res_src = kdlt_pkg::RES_NO_NEIGHBOUR;
                state_d      = kdlt_pkg::S_RESP;
              end else begin
                ctrl.rd_prev = 1'b1;
                state_d      = kdlt_pkg::S_NB_RD;
              end
            end
            default: begin
              ctrl.set_res = 1'b1;
              ctrl.res_src = kdlt_pkg::RES_ENTRY;
              state_d      = kdlt_pkg::S_RESP;
            end
          endcase
        end else if (stat_i.next_null || stat_i.walk_end) begin
          ctrl.set_res = 1'b1;
          ctrl.res_src = kdlt_pkg::RES_NOT_FOUND;
          state_d      = kdlt_pkg::S_RESP;
        end else begin
          ctrl.rd_next   = 1'b1;
          ctrl.walk_step = 1'b1;
        end
      end
      kdlt_pkg::S_REM_A: begin
        ctrl.rem_unlink = 1'b1;
        state_d         = kdlt_pkg::S_REM_B;
      end
      kdlt_pkg::S_REM_B: begin
        ctrl.rem_free = 1'b1;
        state_d       = kdlt_pkg::S_RESP;
      end
      kdlt_pkg::S_NB_RD: begin
        ctrl.set_res = 1'b1;
        ctrl.res_src = kdlt_pkg::RES_ENTRY;
        state_d      = kdlt_pkg::S_RESP;
      end
      kdlt_pkg::S_RESP: begin
        // Hand over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          ctrl.load_out = 1'b1;
          state_d       = kdlt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = kdlt_pkg::S_IDLE;
      end
    endcase
  end

  // Hold the result until the transaction completes
  always_comb begin
    if (ctrl.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kdlt_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `KDLT_ASSERT_NEXT(a_full_insert_answers, clk_i, rst_ni, accept && (in_cmd_i == kdlt_pkg::CMD_INSERT) && stat_i.full, state_q == kdlt_pkg::S_RESP, "full insert did not go straight to response")
  `KDLT_ASSERT_NEXT(a_remove_hit_unlinks, clk_i, rst_ni, (state_q == kdlt_pkg::S_WALK) && stat_i.key_hit && (stat_i.cmd == kdlt_pkg::CMD_REMOVE), state_q == kdlt_pkg::S_REM_A, "remove hit did not start unlinking")
  `KDLT_ASSERT_NEXT(a_result_held, clk_i, rst_ni, out_valid_q && !out_ready_i, out_valid_q, "result dropped before its transaction completed")

endmodule

`default_nettype wire

### sv/kdlt_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

`include "keyed_doubly_linked_table_defines.svh"

module kdlt_dpath #(
  parameter int POOL_DEPTH    = kdlt_pkg::POOL_DEPTH_DEF,
  parameter int PAYLOAD_BYTES = kdlt_pkg::PAYLOAD_BYTES_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire kdlt_pkg::dp_ctrl_t         ctrl_i,
  output kdlt_pkg::dp_stat_t              stat_o,
  input  wire kdlt_pkg::in_item_t         in_item_i,
  input  wire logic [kdlt_pkg::CAP_W-1:0] cap_i,
  output kdlt_pkg::out_item_t             out_item_o
);

  localparam int LW = $clog2(POOL_DEPTH + 1);
  localparam int IW = $clog2(POOL_DEPTH);
  localparam int PW = (PAYLOAD_BYTES >= 4) ? kdlt_pkg::DATA_W : 8 * PAYLOAD_BYTES;
  localparam logic [LW-1:0] NULL_SLOT = LW'(POOL_DEPTH);
  localparam logic [IW-1:0] LAST_STEP = IW'(POOL_DEPTH - 1);

  // Memories
  logic [kdlt_pkg::KEY_W-1:0] key_mem [POOL_DEPTH];
  logic [PW-1:0]              pay_mem [POOL_DEPTH];
  logic [LW-1:0]              nxt_mem [POOL_DEPTH];
  logic [LW-1:0]              prv_mem [POOL_DEPTH];

  logic [kdlt_pkg::KEY_W-1:0] key_rd_q;
  logic [PW-1:0]              pay_rd_q;
  logic [LW-1:0]              nxt_rd_q;
  logic [LW-1:0]              prv_rd_q;

  // Latched command
  logic [kdlt_pkg::CMD_W-1:0] cmd_q;
  logic [kdlt_pkg::KEY_W-1:0] key_q;
  logic [PW-1:0]              data_q;

  // List state
  logic [LW-1:0] head_q, head_d;
  logic [LW-1:0] tail_q, tail_d;
  logic [LW-1:0] free_q, free_d;
  logic [LW-1:0] fresh_q, fresh_d;
  logic [LW-1:0] live_q, live_d;

  // Walk scratch
  logic [LW-1:0] cur_q, cur_d;
  logic [LW-1:0] nb_q, nb_d;
  logic [LW-1:0] pv_q, pv_d;
  logic [IW-1:0] steps_q, steps_d;

  // Result
  logic [kdlt_pkg::STATUS_W-1:0] res_status_q;
  logic [kdlt_pkg::KEY_W-1:0]    res_key_q;
  logic [kdlt_pkg::DATA_W-1:0]   res_data_q;
  kdlt_pkg::out_item_t           out_q;

  logic          rd_en;
  logic [LW-1:0] rd_addr;
  logic          nxt_we, prv_we, ent_we;
  logic [LW-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd;
  logic          from_fresh;

  // Status towards the controller
  always_comb begin
    stat_o.cmd       = cmd_q;
    stat_o.full      = (32'(live_q) >= 32'(cap_i)) || (32'(live_q) >= 32'(POOL_DEPTH))
                       || (free_q == NULL_SLOT);
    stat_o.head_null = (head_q == NULL_SLOT);
    stat_o.tail_null = (tail_q == NULL_SLOT);
    stat_o.key_hit   = (key_rd_q == key_q);
    stat_o.next_null = (nxt_rd_q == NULL_SLOT);
    stat_o.prev_null = (prv_rd_q == NULL_SLOT);
    stat_o.walk_end  = (steps_q == LAST_STEP);
  end

  // Select the read address
  always_comb begin
    rd_en = ctrl_i.rd_free | ctrl_i.rd_head | ctrl_i.rd_next | ctrl_i.rd_prev;
    if (ctrl_i.rd_free) begin
      rd_addr = free_q;
    end else if (ctrl_i.rd_head) begin
      rd_addr = head_q;
    end else if (ctrl_i.rd_prev) begin
      rd_addr = prv_rd_q;
    end else begin
      rd_addr = nxt_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      key_rd_q <= key_mem[rd_addr[IW-1:0]];
      pay_rd_q <= pay_mem[rd_addr[IW-1:0]];
      nxt_rd_q <= nxt_mem[rd_addr[IW-1:0]];
      prv_rd_q <= prv_mem[rd_addr[IW-1:0]];
    end
  end

  // Link writes: one address per memory per cycle
  always_comb begin
    ent_we = ctrl_i.ins_write;
    nxt_we = 1'b0;
    nxt_wa = free_q;
    nxt_wd = NULL_SLOT;
    prv_we = 1'b0;
    prv_wa = free_q;
    prv_wd = tail_q;
    if (ctrl_i.ins_write) begin
      nxt_we = 1'b1;
      prv_we = 1'b1;
    end else if (ctrl_i.ins_link) begin
      nxt_we = 1'b1;
      nxt_wa = pv_q;
      nxt_wd = cur_q;
    end else if (ctrl_i.rem_unlink) begin
      nxt_we = (pv_q != NULL_SLOT);
      nxt_wa = pv_q;
      nxt_wd = nb_q;
      prv_we = (nb_q != NULL_SLOT);
      prv_wa = nb_q;
      prv_wd = pv_q;
    end else if (ctrl_i.rem_free) begin
      nxt_we = 1'b1;
      nxt_wa = cur_q;
      nxt_wd = free_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      key_mem[free_q[IW-1:0]] <= key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      pay_mem[free_q[IW-1:0]] <= data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) begin
      nxt_mem[nxt_wa[IW-1:0]] <= nxt_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prv_we) begin
      prv_mem[prv_wa[IW-1:0]] <= prv_wd;
    end
  end

  // Update list state and walk scratch
  // Slots at and above fresh_q were never handed out and still chain to slot+1
  assign from_fresh = (free_q == fresh_q);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    free_d  = free_q;
    fresh_d = fresh_q;
    live_d  = live_q;
    cur_d   = cur_q;
    nb_d    = nb_q;
    pv_d    = pv_q;
    steps_d = steps_q;
    if (ctrl_i.rd_head) begin
      cur_d   = head_q;
      steps_d = '0;
    end
    if (ctrl_i.walk_step) begin
      cur_d   = nxt_rd_q;
      steps_d = steps_q + IW'(1);
    end
    if (ctrl_i.ins_write) begin
      free_d  = from_fresh ? fresh_q + LW'(1) : nxt_rd_q;
      fresh_d = from_fresh ? fresh_q + LW'(1) : fresh_q;
      tail_d  = free_q;
      if (tail_q == NULL_SLOT) begin
        head_d = free_q;
      end
      live_d = live_q + LW'(1);
      cur_d  = free_q;
      pv_d   = tail_q;
    end
    if (ctrl_i.rem_latch) begin
      nb_d = nxt_rd_q;
      pv_d = prv_rd_q;
    end
    if (ctrl_i.rem_unlink) begin
      if (pv_q == NULL_SLOT) begin
        head_d = nb_q;
      end
      if (nb_q == NULL_SLOT) begin
        tail_d = pv_q;
      end
    end
    if (ctrl_i.rem_free) begin
      free_d = cur_q;
      if (live_q != '0) begin
        live_d = live_q - LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= NULL_SLOT;
      tail_q  <= NULL_SLOT;
      free_q  <= '0;
      fresh_q <= '0;
      live_q  <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      free_q  <= free_d;
      fresh_q <= fresh_d;
      live_q  <= live_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    nb_q    <= nb_d;
    pv_q    <= pv_d;
    steps_q <= steps_d;
  end

  // Capture the accepted command
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch_item) begin
      cmd_q  <= in_item_i.cmd;
      key_q  <= in_item_i.key;
      data_q <= in_item_i.data_word[PW-1:0];
    end
  end

  // Form the result
  always_ff @(posedge clk_i) begin
    if (ctrl_i.set_res) begin
      res_key_q  <= '0;
      res_data_q <= '0;
      case (ctrl_i.res_src)
        kdlt_pkg::RES_OK:           res_status_q <= kdlt_pkg::ST_OK;
        kdlt_pkg::RES_FULL:         res_status_q <= kdlt_pkg::ST_FULL;
        kdlt_pkg::RES_NOT_FOUND:    res_status_q <= kdlt_pkg::ST_NOT_FOUND;
        kdlt_pkg::RES_NO_NEIGHBOUR: res_status_q <= kdlt_pkg::ST_NO_NEIGHBOUR;
        kdlt_pkg::RES_ENTRY: begin
          res_status_q <= kdlt_pkg::ST_OK;
          res_key_q    <= key_rd_q;
          res_data_q   <= kdlt_pkg::DATA_W'(pay_rd_q);
        end
        default:                    res_status_q <= kdlt_pkg::ST_OK;
      endcase
    end
  end

  // Output register; count taken after all list updates
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      out_q.status      <= res_status_q;
      out_q.found_key   <= res_key_q;
      out_q.found_data  <= res_data_q;
      out_q.entry_count <= kdlt_pkg::COUNT_W'(live_q);
    end
  end

  assign out_item_o = out_q;

  `KDLT_ASSERT_IMP(a_head_tail_agree, clk_i, rst_ni, 1'b1, (head_q == NULL_SLOT) == (tail_q == NULL_SLOT), "head and tail disagree on empty list")
  `KDLT_ASSERT_IMP(a_live_within_fresh, clk_i, rst_ni, 1'b1, live_q <= fresh_q, "more live entries than slots ever handed out")
  `KDLT_ASSERT_IMP(a_empty_has_no_head, clk_i, rst_ni, live_q == '0, head_q == NULL_SLOT, "empty table still has a head entry")

endmodule

`default_nettype wire

### sv/keyed_doubly_linked_table.sv
// Keyed table of up to POOL_DEPTH entries held as a doubly linked list in insertion
// order, with freed slots recycled through a free list. Each command returns one
// result: status, key and payload of the returned entry, and the live entry count.
// Insert writes the entry and, when the list was not empty, then links the old tail
// to it. Remove and the find commands walk from the head at one entry per cycle,
// since the key, link and payload memories have a single registered read port:
// find answers on the match, find next or previous first reads the neighbour, and
// remove unlinks and frees the entry before answering; a miss ends at the tail. One
// command is in progress at a time; the next is accepted while the previous result
// waits in the output register. There is no clearing pass after reset: never used
// slots are tracked by a fill count. The capacity_limit register (byte address 0)
// caps the live count.
`timescale 1ns / 1ps
`default_nettype none

module keyed_doubly_linked_table #(
  parameter int POOL_DEPTH    = kdlt_pkg::POOL_DEPTH_DEF,
  parameter int PAYLOAD_BYTES = kdlt_pkg::PAYLOAD_BYTES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire kdlt_pkg::in_item_t          in_item_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output kdlt_pkg::out_item_t              out_item_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [kdlt_pkg::APB_AW-1:0] paddr,
  input  wire logic [kdlt_pkg::APB_DW-1:0] pwdata,
  output logic [kdlt_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);

  logic [kdlt_pkg::CAP_W-1:0] cap_q, cap_d;
  logic                       reg_sel;
  kdlt_pkg::dp_ctrl_t         ctrl;
  kdlt_pkg::dp_stat_t         stat;

  // Register port: single capacity register, zero elsewhere
  assign pready  = 1'b1;
  assign reg_sel = (paddr[kdlt_pkg::APB_AW-1] == kdlt_pkg::REG_CAPACITY);
  assign prdata  = reg_sel ? kdlt_pkg::APB_DW'(cap_q) : '0;

  always_comb begin
    cap_d = cap_q;
    if (psel && penable && pwrite && pready && reg_sel) begin
      cap_d = pwdata[kdlt_pkg::CAP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= kdlt_pkg::CAP_RESET;
    end else begin
      cap_q <= cap_d;
    end
  end

  kdlt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_item_i.cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  kdlt_dpath #(
    .POOL_DEPTH    (POOL_DEPTH),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .in_item_i  (in_item_i),
    .cap_i      (cap_q),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire
